// File: rtl/mwpg_pkg.sv
// Shared types, register codes and the quarter-wave sine table function.
package mwpg_pkg;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SAW    = 2'd3
  } wave_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_WAVEFORM   = 2'd0;
  localparam logic [1:0] CFG_AMPLITUDE  = 2'd1;
  localparam logic [1:0] CFG_PHASE_STEP = 2'd2;

  localparam int AMP_BITS  = 15;
  localparam int STEP_BITS = 32;
  localparam int SINE_FRAC = 15;  // sine table is Q1.15

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_PEAK   = 64'd32767;

  typedef struct packed {
    wave_t                amp_wave;
    logic [AMP_BITS-1:0]  amp;
    logic [STEP_BITS-1:0] step;
  } cfg_t;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic so;
  } pipe_en_t;

  // Control carried along with each transaction
  typedef struct packed {
    logic  ok;
    logic  last;
    wave_t wave;
    logic  neg;
  } ctl_t;

  // Entry k of a quarter-wave table with 2^abits steps: Q30 Taylor series
  // up to x^17/17!, each product truncated to Q30, then rounded to Q1.15.
  function automatic logic [AMP_BITS-1:0] sine_entry(input int k, input int abits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (HALF_PI_Q30 * 64'(k)) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    v = (unsigned'(sum) * SINE_PEAK + (64'd1 << 29)) >> 30;
    if (v > SINE_PEAK) begin
      v = SINE_PEAK;
    end
    return v[AMP_BITS-1:0];
  endfunction

endpackage

// File: rtl/mwpg_front.sv
// Phase accumulator, waveform decode and registered sine table read.
module mwpg_front #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mwpg_pkg::pipe_en_t       en,
  input  logic                     accept,
  input  logic                     in_last,
  input  mwpg_pkg::cfg_t           cfg,
  output mwpg_pkg::ctl_t           ctl_r,
  output logic signed [PHASE_BITS:0] m_r,
  output logic [mwpg_pkg::AMP_BITS-1:0] rom_q_r
);
  import mwpg_pkg::*;

  localparam int MW    = PHASE_BITS + 1;
  localparam int TBL_N = 1 << TABLE_ADDR_BITS;
  localparam logic [TABLE_ADDR_BITS:0]  TBL_END  = (TABLE_ADDR_BITS+1)'(TBL_N);
  localparam logic [PHASE_BITS-1:0]     HALF     = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic signed [MW-1:0]      QUARTER  = MW'(1) <<< (PHASE_BITS - 2);
  localparam logic signed [MW-1:0]      HALF_S   = MW'(1) <<< (PHASE_BITS - 1);
  localparam logic signed [MW-1:0]      SQ_MAG   = MW'(1) <<< SINE_FRAC;

  logic [PHASE_BITS-1:0]      phase_r;
  logic [PHASE_BITS-1:0]      phase_nxt;
  logic [PHASE_BITS-1:0]      step_p;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS:0]   rom_addr;
  logic [PHASE_BITS-1:0]      tri_d;
  logic signed [MW-1:0]       m_nxt;
  ctl_t                       ctl_nxt;
  logic [AMP_BITS-1:0]        sine_rom [0:TBL_N];

  for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, TABLE_ADDR_BITS);
  end

  assign step_p   = PHASE_BITS'(cfg.step);
  assign quad     = phase_r[PHASE_BITS-1 -: 2];
  assign idx      = phase_r[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  // odd quadrants run the table backwards
  assign rom_addr = quad[0] ? (TBL_END - {1'b0, idx}) : {1'b0, idx};
  assign tri_d    = phase_r[PHASE_BITS-1] ? (phase_r - HALF) : (HALF - phase_r);

  always_comb begin
    ctl_nxt.ok   = (cfg.amp != '0) && (step_p != '0);
    ctl_nxt.last = in_last;
    ctl_nxt.wave = cfg.amp_wave;
    ctl_nxt.neg  = quad[1];
    case (cfg.amp_wave)
      WAVE_SQUARE: m_nxt = quad[1] ? -SQ_MAG : SQ_MAG;
      WAVE_TRI:    m_nxt = signed'({1'b0, tri_d}) - QUARTER;
      WAVE_SAW:    m_nxt = signed'({1'b0, phase_r}) - HALF_S;
      default:     m_nxt = '0;
    endcase
  end

  assign phase_nxt = (accept && ctl_nxt.ok) ? (phase_r + step_p) : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ctl_r   <= ctl_nxt;
      m_r     <= m_nxt;
      rom_q_r <= sine_rom[rom_addr];
    end
  end

  a_phase_adv: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl_nxt.ok |=> phase_r == $past(phase_r + step_p))
    else $error("phase did not advance by the step");
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && ctl_nxt.ok) |=> $stable(phase_r))
    else $error("phase moved without a valid sample");

endmodule

// File: rtl/mwpg_scale.sv
// Amplitude multiply, per-waveform floor shift and saturation.
module mwpg_scale #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  mwpg_pkg::pipe_en_t           en,
  input  mwpg_pkg::ctl_t               ctl_in,
  input  logic signed [PHASE_BITS:0]   m_in,
  input  logic [mwpg_pkg::AMP_BITS-1:0] rom_q,
  input  logic [mwpg_pkg::AMP_BITS-1:0] amp,
  output logic signed [SAMPLE_BITS-1:0] sample_r,
  output logic                         ok_r,
  output logic                         last_r
);
  import mwpg_pkg::*;

  localparam int MW = PHASE_BITS + 1;
  localparam int PW = AMP_BITS + 1 + MW;
  localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

  logic signed [MW-1:0] m_eff;
  logic signed [MW-1:0] sine_s;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod_r;
  ctl_t                 ctl2_r;
  logic signed [PW-1:0] shifted;
  logic signed [PW-1:0] sat;

  assign sine_s   = MW'(signed'({1'b0, rom_q}));
  assign m_eff    = (ctl_in.wave == WAVE_SINE) ? (ctl_in.neg ? -sine_s : sine_s) : m_in;
  assign prod_nxt = PW'(signed'({1'b0, amp})) * PW'(m_eff);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= prod_nxt;
      ctl2_r <= ctl_in;
    end
  end

  always_comb begin
    case (ctl2_r.wave)
      WAVE_TRI: shifted = prod_r >>> (PHASE_BITS - 2);
      WAVE_SAW: shifted = prod_r >>> (PHASE_BITS - 1);
      default:  shifted = prod_r >>> SINE_FRAC;
    endcase
    if (shifted > SMAX) begin
      sat = SMAX;
    end else if (shifted < SMIN) begin
      sat = SMIN;
    end else begin
      sat = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (en.so) begin
      sample_r <= ctl2_r.ok ? sat[SAMPLE_BITS-1:0] : '0;
      ok_r     <= ctl2_r.ok;
      last_r   <= ctl2_r.last;
    end
  end

endmodule

// File: rtl/multi_waveform_phase_generator_top.sv
// Top level of the multi-waveform phase generator.
//
// Usage: each transaction on the in_ channel is one sample request; bit 0
// of in_tdata marks the last request of a chunk and comes back on
// out_tlast. Every request yields exactly one out_ transaction carrying
// the sample and an ok flag (ok clear when amplitude or phase step is
// zero; the sample is then 0 and the phase does not move).
// Configuration goes through the cfg_ channel: index 0 waveform (sine,
// square, triangle, sawtooth), 1 amplitude, 2 phase step. cfg_ready is
// always high; write only while no request is in flight.
// Pipeline: three register stages (phase/table read, multiply,
// shift/saturate); the valid bit moves through v1_r, v2_r and vo_r.
// Throughput: one sample per cycle while out_tready is high; the sine
// table is a ROM with a registered read port, which sets stage one.
// Stalls: each stage has its own valid bit; a stage loads when it is
// empty or the one after it moves, so requests keep flowing into empty
// stages while a finished sample waits on out_tready.
// Reset (rst_n low at a clock edge): phase 0, configuration registers 0,
// pipeline empty, data regs not reset; no table initialization is needed.
module multi_waveform_phase_generator_top #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] chunk_end
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [SAMPLE_BITS-1:0] sample, [SAMPLE_BITS] ok, zero fill above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mwpg_pkg::*;

  cfg_t                        cfg_r;
  pipe_en_t                    en;
  logic                        accept;
  logic                        v1_r;
  logic                        v2_r;
  logic                        vo_r;
  ctl_t                        ctl1;
  logic signed [PHASE_BITS:0]  m1;
  logic [AMP_BITS-1:0]         rom1;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                        ok;
  logic                        last;

  // Configuration registers; an index past phase_step is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amp_wave <= WAVE_SINE;
      cfg_r.amp      <= '0;
      cfg_r.step     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WAVEFORM:   cfg_r.amp_wave <= wave_t'(cfg_data[1:0]);
        CFG_AMPLITUDE:  cfg_r.amp      <= cfg_data[AMP_BITS-1:0];
        CFG_PHASE_STEP: cfg_r.step     <= cfg_data[STEP_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // Stage enables: a stage moves when empty or when its successor moves
  assign en.so     = !vo_r || out_tready;
  assign en.s2     = !v2_r || en.so;
  assign en.s1     = !v1_r || en.s2;
  assign in_tready = en.s1;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= accept;
      if (en.s2) v2_r <= v1_r;
      if (en.so) vo_r <= v2_r;
    end
  end

  mwpg_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .accept  (accept),
    .in_last (in_tdata[0]),
    .cfg     (cfg_r),
    .ctl_r   (ctl1),
    .m_r     (m1),
    .rom_q_r (rom1)
  );

  mwpg_scale #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk      (clk),
    .en       (en),
    .ctl_in   (ctl1),
    .m_in     (m1),
    .rom_q    (rom1),
    .amp      (cfg_r.amp),
    .sample_r (sample),
    .ok_r     (ok),
    .last_r   (last)
  );

  assign out_tvalid = vo_r;
  assign out_tlast  = last;

  always_comb begin
    out_tdata                  = '0;
    out_tdata[SAMPLE_BITS-1:0] = sample;
    out_tdata[SAMPLE_BITS]     = ok;
  end

  a_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !ok |-> sample == '0)
    else $error("sample not zero with ok clear");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("input stalled with stage one empty");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && en.s2 |=> v2_r)
    else $error("transaction lost between stages");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the multi-waveform phase generator top level.
`timescale 1ns / 1ps

module testbench;
  import mwpg_pkg::*;

  localparam logic [1:0] CFG_SPARE   = 2'd3;  // decoded by nothing
  localparam int         WATCH_LIMIT = 1000;
  localparam int         TAIL_CYCLES = 8;     // pipeline is 3 deep
  localparam longint     HALF_TURN    = 64'sd2147483648;
  localparam longint     QUARTER_TURN = 64'sd1073741824;

  typedef struct {
    logic signed [15:0] sample;
    logic               ok;
    logic               last;
  } gen_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [0] chunk_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [15:0] sample, [16] ok, [23:17] zero
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  multi_waveform_phase_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Mirror of the generator: registers, phase accumulator, sine table.
  wave_t       gen_wave = WAVE_SINE;
  logic [14:0] gen_amp = '0;
  logic [31:0] gen_step = '0;
  logic [31:0] gen_phase = '0;
  int          quarter_sine [0:1024];

  gen_result_t pending_samples [$];
  int          mismatches = 0;
  int          requests_sent = 0;
  bit          idle_on = 1'b1;
  bit          in_busy = 1'b0;   // in_tvalid left high by the last transaction
  bit          cfg_busy = 1'b0;  // same for cfg_valid
  int          stall_left = 0;
  int          quiet_cycles = 0;

  // Quarter-wave table: Q30 Taylor series of sin, rounded to Q1.15.
  function automatic void build_quarter_sine();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          acc;
    for (int k = 0; k <= 1024; k++) begin
      x    = (64'd1686629713 * 64'(k)) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      quarter_sine[k] = (v > 64'd32767) ? 32767 : int'(v);
    end
  endfunction

  // Waveform level at phase ph before saturation.
  function automatic longint wave_level(input logic [31:0] ph);
    longint      amp_l;
    longint      lvl;
    longint      tri_dist;
    logic [10:0] idx;
    amp_l = longint'(gen_amp);
    case (gen_wave)
      WAVE_SINE: begin
        idx = {1'b0, ph[29:20]};
        if (ph[30]) begin
          idx = 11'd1024 - idx;   // falling half of each half turn
        end
        lvl = amp_l * longint'(quarter_sine[idx]);
        if (ph[31]) begin
          lvl = -lvl;
        end
        return lvl >>> 15;
      end
      WAVE_SQUARE: return ph[31] ? -amp_l : amp_l;
      WAVE_TRI: begin
        tri_dist = longint'(ph) - HALF_TURN;
        if (tri_dist < 0) begin
          tri_dist = -tri_dist;
        end
        return (amp_l * (tri_dist - QUARTER_TURN)) >>> 30;
      end
      default: return (amp_l * (longint'(ph) - HALF_TURN)) >>> 31;
    endcase
  endfunction

  // Expected sample for one accepted request; steps the phase when enabled.
  function automatic void predict_sample(input logic chunk_end);
    gen_result_t r;
    longint      lvl;
    r.last   = chunk_end;
    r.ok     = 1'b0;
    r.sample = '0;
    if (gen_amp != '0 && gen_step != '0) begin
      lvl = wave_level(gen_phase);
      if (lvl > 32767) begin
        lvl = 32767;
      end
      if (lvl < -32768) begin
        lvl = -32768;
      end
      r.ok      = 1'b1;
      r.sample  = lvl[15:0];
      gen_phase = gen_phase + gen_step;
    end
    pending_samples.push_back(r);
  endfunction

  // Output ready with random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker: each output transaction against the oldest expectation.
  always @(posedge clk) begin
    gen_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected output transaction: sample %0d ok %0b last %0b",
               $signed(out_tdata[15:0]), out_tdata[16], out_tlast);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (out_tdata[15:0] !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, $signed(out_tdata[15:0]));
          mismatches++;
        end
        if (out_tdata[16] !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, out_tdata[16]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
        if (out_tdata[23:17] !== 7'd0) begin
          $error("tdata pad: expected 0, got %0h", out_tdata[23:17]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One sample request; in_tvalid stays high afterwards unless a gap follows.
  task automatic send_request(input logic chunk_end);
    if (cfg_busy) begin
      cfg_valid <= 1'b0;
      cfg_busy = 1'b0;
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      if (in_busy) begin
        in_tvalid <= 1'b0;
        in_busy = 1'b0;
      end
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, chunk_end};
    in_busy = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_sample(chunk_end);
    requests_sent++;
  endtask

  // Stop requesting and wait for every outstanding sample.
  task automatic wait_drained();
    if (in_busy) begin
      in_tvalid <= 1'b0;
      in_busy = 1'b0;
    end
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // Register write; cfg_valid is dropped by the next request or at the end.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_busy = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WAVEFORM:   gen_wave = wave_t'(data[1:0]);
      CFG_AMPLITUDE:  gen_amp = data[14:0];
      CFG_PHASE_STEP: gen_step = data;
      default: ;
    endcase
  endtask

  // Full reprogram at an idle point; junk in the unused upper bits.
  task automatic program_config(input wave_t wave, input logic [14:0] amp,
                                input logic [31:0] step);
    logic [31:0] wdata;
    logic [31:0] adata;
    wdata = $urandom;
    wdata[1:0] = wave;
    adata = $urandom;
    adata[14:0] = amp;
    wait_drained();
    cfg_write(CFG_WAVEFORM, wdata);
    cfg_write(CFG_AMPLITUDE, adata);
    cfg_write(CFG_PHASE_STEP, step);
  endtask

  // Everything at reset value: output disabled.
  task automatic check_reset_values();
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // Zero step or zero amplitude: sample 0, ok low, phase frozen.
  task automatic check_disabled_output();
    program_config(WAVE_SQUARE, 15'd100, 32'd0);
    send_request(1'b1);
    program_config(WAVE_SAW, 15'd0, 32'd1000);
    send_request(1'b0);
  endtask

  // Full amplitude, quarter-turn steps: peaks, zero crossings, wrap.
  task automatic check_waveform_corners();
    for (int w = 0; w < 4; w++) begin
      program_config(wave_t'(w), 15'h7FFF, 32'h4000_0000);
      for (int k = 0; k < 4; k++) begin
        send_request(k == 3);
      end
    end
    // amplitude 1 with the largest step: floor rounding on negatives
    program_config(WAVE_SAW, 15'd1, 32'hFFFF_FFFF);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // Upper data bits are dropped and the spare index changes nothing.
  task automatic check_register_masking();
    wait_drained();
    cfg_write(CFG_WAVEFORM, 32'hFFFF_FFFE);
    cfg_write(CFG_AMPLITUDE, 32'hFFFF_8005);
    cfg_write(CFG_PHASE_STEP, 32'h1234_5678);
    cfg_write(CFG_SPARE, 32'h0000_0000);
    cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  function automatic logic [14:0] pick_amp();
    case ($urandom_range(0, 7))
      0:       return 15'd0;
      1:       return 15'd1;
      2:       return 15'h7FFF;
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(1, 4096));
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random settings per phase, random chunk marks, idle bursts on both sides.
  task automatic run_random_phases();
    int n;
    while (requests_sent < 1500) begin
      program_config(wave_t'($urandom_range(0, 3)), pick_amp(), pick_step());
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CFG_SPARE, $urandom);
      end
      n = $urandom_range(20, 80);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && $urandom_range(0, 2) == 0) begin
          wait_drained();   // sender holds off until the pipe is empty
        end
        send_request(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Last stretch at full rate, no idling on either side.
  task automatic run_back_to_back();
    wait_drained();
    idle_on = 1'b0;
    repeat (5) @(posedge clk);   // let a stall burst under way run out
    program_config(WAVE_SINE, 15'h7FFF, 32'h0040_0001);
    for (int k = 0; k < 130; k++) begin
      send_request(1'($urandom_range(0, 1)));
    end
    program_config(WAVE_TRI, pick_amp(), $urandom);
    for (int k = 0; k < 120; k++) begin
      send_request(1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    build_quarter_sine();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reset_values();
    check_disabled_output();
    check_waveform_corners();
    check_register_masking();
    run_random_phases();
    run_back_to_back();
    wait_drained();
    if (cfg_busy) begin
      cfg_valid <= 1'b0;
      cfg_busy = 1'b0;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mwpg_pkg.sv
rtl/mwpg_front.sv
rtl/mwpg_scale.sv
rtl/multi_waveform_phase_generator_top.sv
test/testbench.sv
